### rtl/flba_pkg.sv
// Package for the free-list block allocator: request, response and pool entry types, codes.
package flba_pkg;

    localparam int SIZE_W = 17;
    localparam int ADDR_W = 16;
    localparam int POOL_W = 7;

    localparam int POOL_DEPTH_DEF = 64;
    localparam int HEAP_WORDS_DEF = 65536;

    localparam logic [SIZE_W-1:0] HEAP_LIMIT_RESET = 17'h10000;
    localparam logic [SIZE_W-1:0] HEAP_SPAN_MAX    = 17'h1FFFF;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [2:0] OUT_FRESH    = 3'd0;
    localparam logic [2:0] OUT_EXACT    = 3'd1;
    localparam logic [2:0] OUT_SPLIT    = 3'd2;
    localparam logic [2:0] OUT_OOM      = 3'd3;
    localparam logic [2:0] OUT_RELEASED = 3'd4;
    localparam logic [2:0] OUT_FULL     = 3'd5;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] block_size;
        logic [ADDR_W-1:0] block_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [2:0]        outcome;
        logic [POOL_W-1:0] entries_in_pool;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] length;
    } entry_t;

endpackage

### rtl/free_list_block_allocator.sv
// Free-list block allocator: pool memory, scan and compaction sequencer, bump-pointer heap.
// A request is taken only while the sequencer is idle. A release goes from idle straight
// to the final state. An allocate scans the pool from the top entry down, one memory read per
// cycle, and when an entry is removed the entries above it are moved down one per cycle. Both
// passes are bound by the single read port of the pool memory. A finished response waits in
// an output register while the next request is taken. The pool needs no clearing after
// reset: only entries below the fill count are ever read.
module free_list_block_allocator
#(
    parameter int POOL_DEPTH = flba_pkg::POOL_DEPTH_DEF,
    parameter int HEAP_WORDS = flba_pkg::HEAP_WORDS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  flba_pkg::req_t                  req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output flba_pkg::rsp_t                  rsp_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [flba_pkg::SIZE_W-1:0]     cfg_data
);

    import flba_pkg::*;

    localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);
    localparam logic [SIZE_W-1:0] HEAP_CAP =
        (HEAP_WORDS > int'(HEAP_SPAN_MAX)) ? HEAP_SPAN_MAX : SIZE_W'(HEAP_WORDS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;

    entry_t            mem [POOL_DEPTH];
    entry_t            rd_data_reg;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [SIZE_W-1:0] heap_reg, heap_next;
    logic [SIZE_W-1:0] limit_reg, limit_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IW-1:0]     rd_idx_reg, rd_idx_next;
    req_t              req_reg, req_next;
    logic              exact_reg, exact_next;
    logic              bigger_reg, bigger_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    logic [ADDR_W-1:0] hit_start_reg, hit_start_next;
    logic [SIZE_W-1:0] hit_len_reg, hit_len_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    entry_t            wr_data;
    logic              rsp_free;
    logic [SIZE_W-1:0] lim_eff;
    logic [SIZE_W:0]   heap_sum;

    assign req_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign lim_eff   = (limit_reg < HEAP_CAP) ? limit_reg : HEAP_CAP;
    assign heap_sum  = {1'b0, heap_reg} + {1'b0, req_reg.block_size};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        heap_next      = heap_reg;
        limit_next     = limit_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        req_next       = req_reg;
        exact_next     = exact_reg;
        bigger_next    = bigger_reg;
        hit_idx_next   = hit_idx_reg;
        hit_start_next = hit_start_reg;
        hit_len_next   = hit_len_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req_data;
                    exact_next  = 1'b0;
                    bigger_next = 1'b0;
                    cnt_next    = count_reg;
                    state_next  = (req_data.op == OP_RELEASE) ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // top-down scan: first exact match wins, last larger entry seen is the lowest
                if (rd_vld_reg && rd_data_reg.length == req_reg.block_size)
                begin
                    exact_next     = 1'b1;
                    hit_idx_next   = rd_idx_reg;
                    hit_start_next = rd_data_reg.start;
                    cnt_next       = CW'(rd_idx_reg) + 1'b1;
                    state_next     = ST_SHIFT;
                end
                else
                begin
                    if (rd_vld_reg && rd_data_reg.length > req_reg.block_size)
                    begin
                        bigger_next    = 1'b1;
                        hit_idx_next   = rd_idx_reg;
                        hit_start_next = rd_data_reg.start;
                        hit_len_next   = rd_data_reg.length;
                    end
                    if (cnt_reg != '0)
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = IW'(cnt_reg - 1'b1);
                        rd_idx_next = IW'(cnt_reg - 1'b1);
                        rd_vld_next = 1'b1;
                        cnt_next    = cnt_reg - 1'b1;
                    end
                    else if (!rd_vld_reg)
                    begin
                        if (bigger_reg)
                        begin
                            cnt_next   = CW'(hit_idx_reg) + 1'b1;
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_SHIFT:
            begin
                // move entries above the removed one down by one
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg - 1'b1;
                    wr_data = rd_data_reg;
                end
                if (cnt_reg < count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = IW'(cnt_reg);
                    rd_idx_next = IW'(cnt_reg);
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.granted_address  = '0;
                    if (req_reg.op == OP_RELEASE)
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            rsp_next.outcome = OUT_FULL;
                        end
                        else
                        begin
                            wr_en                 = 1'b1;
                            wr_addr               = IW'(count_reg);
                            wr_data.start         = req_reg.block_address;
                            wr_data.length        = req_reg.block_size;
                            count_next            = count_reg + 1'b1;
                            rsp_next.outcome      = OUT_RELEASED;
                        end
                    end
                    else if (exact_reg)
                    begin
                        rsp_next.granted_address = hit_start_reg;
                        count_next               = count_reg - 1'b1;
                        rsp_next.outcome         = OUT_EXACT;
                    end
                    else if (bigger_reg)
                    begin
                        // remainder goes to the slot freed at the top
                        wr_en                    = 1'b1;
                        wr_addr                  = IW'(count_reg - 1'b1);
                        wr_data.start            = hit_start_reg
                                                   + req_reg.block_size[ADDR_W-1:0];
                        wr_data.length           = hit_len_reg - req_reg.block_size;
                        rsp_next.granted_address = hit_start_reg;
                        rsp_next.outcome         = OUT_SPLIT;
                    end
                    else if (heap_sum > {1'b0, lim_eff})
                    begin
                        rsp_next.outcome = OUT_OOM;
                    end
                    else
                    begin
                        rsp_next.granted_address = heap_reg[ADDR_W-1:0];
                        heap_next                = heap_sum[SIZE_W-1:0];
                        rsp_next.outcome         = OUT_FRESH;
                    end
                    rsp_next.entries_in_pool = POOL_W'(count_next);
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            heap_reg      <= '0;
            limit_reg     <= HEAP_LIMIT_RESET;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            exact_reg     <= 1'b0;
            bigger_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            heap_reg      <= heap_next;
            limit_reg     <= limit_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            exact_reg     <= exact_next;
            bigger_reg    <= bigger_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        req_reg       <= req_next;
        hit_idx_reg   <= hit_idx_next;
        hit_start_reg <= hit_start_next;
        hit_len_reg   <= hit_len_next;
        rsp_reg       <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("pool fill count above depth");

    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        heap_reg <= HEAP_CAP)
        else $error("bump pointer beyond heap");

    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && rd_vld_reg) |->
            (rd_idx_reg != '0 && CW'(rd_idx_reg) < count_reg))
        else $error("compaction write outside pool");

    a_exact_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && rsp_free && req_reg.op == OP_ALLOC && exact_reg) |=>
            (count_reg == $past(count_reg) - 1'b1 && rsp_valid_reg))
        else $error("exact reuse did not shrink pool");

endmodule
